[rtl/total_least_squares_line_fit_defines.svh]
// Assertion macros shared by the line fit checker.
`ifndef TOTAL_LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define TOTAL_LEAST_SQUARES_LINE_FIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TLSLF_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("line fit check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TLSLF_ASSERT_NXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("line fit check failed");

`endif

[rtl/tlslf_pkg.sv]
// Shared types, codes and constants of the line fit block.
`timescale 1ns / 1ps
package tlslf_pkg;

   localparam int XY_W  = 34;   // CORDIC x / y datapath, Q2.30 plus headroom
   localparam int ANG_W = 34;   // binary angle, full turn = 2^32
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sh080000000;
   localparam logic signed [XY_W-1:0]  INV_GAIN  = 34'sd652032874;

   // multiply sequence codes
   localparam logic [2:0] OP_NSS  = 3'd0;
   localparam logic [2:0] OP_SS2  = 3'd1;
   localparam logic [2:0] OP_NZZ  = 3'd2;
   localparam logic [2:0] OP_ZZ2  = 3'd3;
   localparam logic [2:0] OP_NSZ  = 3'd4;
   localparam logic [2:0] OP_SZ2  = 3'd5;
   localparam logic [2:0] OP_NUMS = 3'd6;
   localparam logic [2:0] OP_NUMZ = 3'd7;

   typedef struct packed {
      logic       take;
      logic       mul_load;
      logic       mul_step;
      logic       mul_wb;
      logic [2:0] mul_op;
      logic       norm_load;
      logic       norm_shift;
      logic       vec_load;
      logic       rot_load;
      logic       cordic_step;
      logic       cordic_rot;
      logic [4:0] step_idx;
      logic       q15_load;
      logic       div_load;
      logic       div_step;
      logic       out_load;
      logic       out_fit;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic n_ok;
      logic aniso;
      logic norm_done;
      logic out_free;
   } status_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = 34'sd536870912;
         5'd1:    v = 34'sd316933406;
         5'd2:    v = 34'sd167458907;
         5'd3:    v = 34'sd85004756;
         5'd4:    v = 34'sd42667331;
         5'd5:    v = 34'sd21354465;
         5'd6:    v = 34'sd10679838;
         5'd7:    v = 34'sd5340245;
         5'd8:    v = 34'sd2670163;
         5'd9:    v = 34'sd1335087;
         5'd10:   v = 34'sd667544;
         5'd11:   v = 34'sd333772;
         5'd12:   v = 34'sd166886;
         5'd13:   v = 34'sd83443;
         5'd14:   v = 34'sd41722;
         5'd15:   v = 34'sd20861;
         5'd16:   v = 34'sd10430;
         5'd17:   v = 34'sd5215;
         5'd18:   v = 34'sd2608;
         5'd19:   v = 34'sd1304;
         5'd20:   v = 34'sd652;
         5'd21:   v = 34'sd326;
         5'd22:   v = 34'sd163;
         5'd23:   v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/tlslf_ctrl.sv]
// Sequencer of the line fit: accumulate, multiply, normalize, CORDIC, divide, output.
`timescale 1ns / 1ps
module tlslf_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_stall,
   input  tlslf_pkg::status_type  status,
   output tlslf_pkg::cmd_type     cmd
);

   localparam int STEPS = (CORDIC_STEPS > tlslf_pkg::ATAN_ENTRIES) ?
                          tlslf_pkg::ATAN_ENTRIES : CORDIC_STEPS;
   localparam logic [5:0] LAST_STEP = 6'(STEPS - 1);
   localparam logic [5:0] LAST_BIT  = 6'd63;

   localparam logic [3:0] S_ACC   = 4'd0;
   localparam logic [3:0] S_DRAIN = 4'd1;
   localparam logic [3:0] S_MLOAD = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_MWB   = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_NORM  = 4'd6;
   localparam logic [3:0] S_VEC   = 4'd7;
   localparam logic [3:0] S_ANGLE = 4'd8;
   localparam logic [3:0] S_ROT   = 4'd9;
   localparam logic [3:0] S_QUANT = 4'd10;
   localparam logic [3:0] S_DLOAD = 4'd11;
   localparam logic [3:0] S_DIV   = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] op_ff, op_in;
   logic       fit_ff, fit_in;

   assign req_stall = (state_ff != S_ACC);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      fit_in   = fit_ff;
      cmd      = '0;
      cmd.mul_op   = op_ff;
      cmd.step_idx = cnt_ff[4:0];
      cmd.out_fit  = fit_ff;
      case (state_ff)
         S_ACC: begin
            cmd.take = req_valid;
            if (req_valid && req_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (status.pipe_empty) begin
               op_in    = tlslf_pkg::OP_NSS;
               state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            cmd.mul_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (cnt_ff == LAST_BIT) state_in = S_MWB;
         end
         S_MWB: begin
            cmd.mul_wb = 1'b1;
            if (op_ff == tlslf_pkg::OP_SZ2) begin
               state_in = S_CHECK;
            end else if (op_ff == tlslf_pkg::OP_NUMZ) begin
               state_in = S_DLOAD;
            end else begin
               op_in    = op_ff + 3'd1;
               state_in = S_MLOAD;
            end
         end
         S_CHECK: begin
            if (status.n_ok && status.aniso) begin
               cmd.norm_load = 1'b1;
               fit_in        = 1'b1;
               state_in      = S_NORM;
            end else begin
               fit_in   = 1'b0;
               state_in = S_OUT;
            end
         end
         S_NORM: begin
            if (status.norm_done) begin
               cmd.vec_load = 1'b1;
               cnt_in       = '0;
               state_in     = S_VEC;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         S_VEC: begin
            cmd.cordic_step = 1'b1;
            cnt_in          = cnt_ff + 6'd1;
            if (cnt_ff == LAST_STEP) state_in = S_ANGLE;
         end
         S_ANGLE: begin
            cmd.rot_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_ROT;
         end
         S_ROT: begin
            cmd.cordic_step = 1'b1;
            cmd.cordic_rot  = 1'b1;
            cnt_in          = cnt_ff + 6'd1;
            if (cnt_ff == LAST_STEP) state_in = S_QUANT;
         end
         S_QUANT: begin
            cmd.q15_load = 1'b1;
            op_in        = tlslf_pkg::OP_NUMS;
            state_in     = S_MLOAD;
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (cnt_ff == LAST_BIT) state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         cnt_ff   <= '0;
         op_ff    <= tlslf_pkg::OP_NSS;
         fit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
         fit_ff   <= fit_in;
      end
   end

endmodule

[rtl/tlslf_dpath.sv]
// Datapath of the line fit: accumulators, shift-add multiplier, CORDIC, divider.
`timescale 1ns / 1ps
module tlslf_dpath #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tlslf_pkg::cmd_type        cmd,
   output tlslf_pkg::status_type     status,
   input  logic signed [19:0]        req_s_pos,
   input  logic signed [19:0]        req_z_pos,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic signed [15:0]        rsp_normal_s,
   output logic signed [15:0]        rsp_normal_z,
   output logic signed [23:0]        rsp_line_offset,
   output logic                      rsp_fit_valid
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM1_W = 20 + CNT_W;
   localparam int SUM2_W = 40 + CNT_W;
   localparam int REM_W  = CNT_W + 16;
   localparam int XY_W   = tlslf_pkg::XY_W;
   localparam int ANG_W  = tlslf_pkg::ANG_W;
   localparam logic [CNT_W-1:0] MAXP = CNT_W'(MAX_POINTS);

   // input pipeline
   logic                     v1_ff, v1_in, v2_ff, v2_in;
   logic signed [19:0]       s1_ff, z1_ff;
   logic signed [39:0]       pss_ff, pzz_ff, psz_ff;
   logic signed [19:0]       s2_ff, z2_ff;

   // accumulators
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SUM1_W-1:0] ss_ff, ss_in, sz1_ff, sz1_in;
   logic signed [SUM2_W-1:0] sss_ff, sss_in, szz_ff, szz_in, ssz_ff, ssz_in;

   // multiplier and scatter terms
   logic [63:0] mx_ff, my_ff, mp_ff, mx_sel, my_sel;
   logic [63:0] a_ff, b_ff, c_ff, num_ff, diff, c_mag;

   // normalizer, CORDIC
   logic [63:0]             nx_ff, ny_ff;
   logic signed [XY_W-1:0]  cx_ff, cx_in, cy_ff, cy_in, dxs, dys;
   logic signed [ANG_W-1:0] cz_ff, cz_in, atn, phi1, phi2;
   logic                    sig_pos;
   logic signed [15:0]      ns_ff, nz_ff, ns0, nz0, ns1, nz1;

   // divider
   logic [63:0]       dvd_ff, mag_num;
   logic [REM_W-1:0]  rem_ff, rs, den;
   logic              ge;

   logic [23:0]       off;
   logic              rv_ff;

   function automatic logic signed [15:0] q15(input logic signed [XY_W:0] v);
      logic signed [XY_W:0] r;
      r = (v + (XY_W+1)'(16384)) >>> 15;
      if (r > (XY_W+1)'(32767))       return 16'sd32767;
      else if (r < -(XY_W+1)'(32767)) return -16'sd32767;
      else                            return r[15:0];
   endfunction

   // accumulation
   assign v1_in = cmd.take;
   assign v2_in = v1_ff;

   always_comb begin
      cnt_in = cnt_ff;
      ss_in  = ss_ff;
      sz1_in = sz1_ff;
      sss_in = sss_ff;
      szz_in = szz_ff;
      ssz_in = ssz_ff;
      if (cmd.out_load) begin
         cnt_in = '0; ss_in = '0; sz1_in = '0;
         sss_in = '0; szz_in = '0; ssz_in = '0;
      end else if (v2_ff && (cnt_ff < MAXP)) begin
         cnt_in = cnt_ff + 1'b1;
         ss_in  = ss_ff  + {{(SUM1_W-20){s2_ff[19]}}, s2_ff};
         sz1_in = sz1_ff + {{(SUM1_W-20){z2_ff[19]}}, z2_ff};
         sss_in = sss_ff + {{(SUM2_W-40){pss_ff[39]}}, pss_ff};
         szz_in = szz_ff + {{(SUM2_W-40){pzz_ff[39]}}, pzz_ff};
         ssz_in = ssz_ff + {{(SUM2_W-40){psz_ff[39]}}, psz_ff};
      end
   end

   // multiplier operand select, all mod 2^64
   always_comb begin
      case (cmd.mul_op)
         tlslf_pkg::OP_NSS: begin
            mx_sel = {{(64-SUM2_W){sss_ff[SUM2_W-1]}}, sss_ff};
            my_sel = {{(64-CNT_W){1'b0}}, cnt_ff};
         end
         tlslf_pkg::OP_SS2: begin
            mx_sel = {{(64-SUM1_W){ss_ff[SUM1_W-1]}}, ss_ff};
            my_sel = mx_sel;
         end
         tlslf_pkg::OP_NZZ: begin
            mx_sel = {{(64-SUM2_W){szz_ff[SUM2_W-1]}}, szz_ff};
            my_sel = {{(64-CNT_W){1'b0}}, cnt_ff};
         end
         tlslf_pkg::OP_ZZ2: begin
            mx_sel = {{(64-SUM1_W){sz1_ff[SUM1_W-1]}}, sz1_ff};
            my_sel = mx_sel;
         end
         tlslf_pkg::OP_NSZ: begin
            mx_sel = {{(64-SUM2_W){ssz_ff[SUM2_W-1]}}, ssz_ff};
            my_sel = {{(64-CNT_W){1'b0}}, cnt_ff};
         end
         tlslf_pkg::OP_SZ2: begin
            mx_sel = {{(64-SUM1_W){ss_ff[SUM1_W-1]}}, ss_ff};
            my_sel = {{(64-SUM1_W){sz1_ff[SUM1_W-1]}}, sz1_ff};
         end
         tlslf_pkg::OP_NUMS: begin
            mx_sel = {{(64-SUM1_W){ss_ff[SUM1_W-1]}}, ss_ff};
            my_sel = {{48{ns_ff[15]}}, ns_ff};
         end
         tlslf_pkg::OP_NUMZ: begin
            mx_sel = {{(64-SUM1_W){sz1_ff[SUM1_W-1]}}, sz1_ff};
            my_sel = {{48{nz_ff[15]}}, nz_ff};
         end
         default: begin
            mx_sel = '0;
            my_sel = '0;
         end
      endcase
   end

   assign diff  = a_ff - b_ff;
   assign c_mag = c_ff[63] ? (64'd0 - c_ff) : c_ff;

   // CORDIC step, shared by vectoring and rotation
   assign dxs = cy_ff >>> cmd.step_idx;
   assign dys = cx_ff >>> cmd.step_idx;
   assign atn = tlslf_pkg::atan_entry(cmd.step_idx);
   assign sig_pos = cmd.cordic_rot ? !cz_ff[ANG_W-1] : cy_ff[XY_W-1];
   assign phi1 = diff[63] ? (tlslf_pkg::HALF_TURN - cz_ff) : cz_ff;
   assign phi2 = c_ff[63] ? -phi1 : phi1;

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (cmd.vec_load) begin
         cx_in = {{(XY_W-30){1'b0}}, nx_ff[29:0]};
         cy_in = {{(XY_W-30){1'b0}}, ny_ff[29:0]};
         cz_in = '0;
      end else if (cmd.rot_load) begin
         cx_in = tlslf_pkg::INV_GAIN;
         cy_in = '0;
         cz_in = phi2 >>> 1;
      end else if (cmd.cordic_step) begin
         if (sig_pos) begin
            cx_in = cx_ff - dxs;
            cy_in = cy_ff + dys;
            cz_in = cz_ff - atn;
         end else begin
            cx_in = cx_ff + dxs;
            cy_in = cy_ff - dys;
            cz_in = cz_ff + atn;
         end
      end
   end

   // quantize to Q1.15 and fold the sign so that the z component is nonnegative
   always_comb begin
      ns0 = q15(-{cy_ff[XY_W-1], cy_ff});
      nz0 = q15({cx_ff[XY_W-1], cx_ff});
      ns1 = ns0;
      nz1 = nz0;
      if (nz0 < 0) begin
         ns1 = -ns0;
         nz1 = -nz0;
      end
      if ((nz1 == 16'sd0) && (ns1 < 0)) ns1 = -ns1;
   end

   // divider: round(|num| / (n * 2^15))
   assign mag_num = num_ff[63] ? (64'd0 - num_ff) : num_ff;
   assign den     = {1'b0, cnt_ff, 15'b0};
   assign rs      = {rem_ff[REM_W-2:0], dvd_ff[63]};
   assign ge      = (rs >= den);

   always_comb begin
      if (num_ff[63]) begin
         off = (dvd_ff > 64'd8388607) ? 24'h7FFFFF : dvd_ff[23:0];
      end else begin
         off = (dvd_ff > 64'd8388608) ? 24'h800000 : (24'd0 - dvd_ff[23:0]);
      end
   end

   assign status.pipe_empty = !v1_ff && !v2_ff;
   assign status.n_ok       = (cnt_ff >= CNT_W'(2));
   assign status.aniso      = (|diff) || (|c_ff);
   assign status.norm_done  = ~|(nx_ff[63:30] | ny_ff[63:30]);
   assign status.out_free   = !rv_ff || !rsp_stall;

   assign rsp_valid = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         rv_ff  <= 1'b0;
         cnt_ff <= '0;
         ss_ff  <= '0;
         sz1_ff <= '0;
         sss_ff <= '0;
         szz_ff <= '0;
         ssz_ff <= '0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         rv_ff  <= cmd.out_load || (rv_ff && rsp_stall);
         cnt_ff <= cnt_in;
         ss_ff  <= ss_in;
         sz1_ff <= sz1_in;
         sss_ff <= sss_in;
         szz_ff <= szz_in;
         ssz_ff <= ssz_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         s1_ff <= req_s_pos;
         z1_ff <= req_z_pos;
      end
      pss_ff <= s1_ff * s1_ff;
      pzz_ff <= z1_ff * z1_ff;
      psz_ff <= s1_ff * z1_ff;
      s2_ff  <= s1_ff;
      z2_ff  <= z1_ff;

      if (cmd.mul_load) begin
         mx_ff <= mx_sel;
         my_ff <= my_sel;
         mp_ff <= '0;
      end else if (cmd.mul_step) begin
         mp_ff <= mp_ff + (my_ff[0] ? mx_ff : 64'd0);
         mx_ff <= {mx_ff[62:0], 1'b0};
         my_ff <= {1'b0, my_ff[63:1]};
      end

      if (cmd.mul_wb) begin
         case (cmd.mul_op)
            tlslf_pkg::OP_NSS:  a_ff   <= mp_ff;
            tlslf_pkg::OP_SS2:  a_ff   <= a_ff - mp_ff;
            tlslf_pkg::OP_NZZ:  b_ff   <= mp_ff;
            tlslf_pkg::OP_ZZ2:  b_ff   <= b_ff - mp_ff;
            tlslf_pkg::OP_NSZ:  c_ff   <= mp_ff;
            tlslf_pkg::OP_SZ2:  c_ff   <= c_ff - mp_ff;
            tlslf_pkg::OP_NUMS: num_ff <= mp_ff;
            tlslf_pkg::OP_NUMZ: num_ff <= num_ff + mp_ff;
            default:            num_ff <= num_ff;
         endcase
      end

      if (cmd.norm_load) begin
         nx_ff <= diff[63] ? (64'd0 - diff) : diff;
         ny_ff <= {c_mag[62:0], 1'b0};
      end else if (cmd.norm_shift) begin
         nx_ff <= {1'b0, nx_ff[63:1]};
         ny_ff <= {1'b0, ny_ff[63:1]};
      end

      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;

      if (cmd.q15_load) begin
         ns_ff <= ns1;
         nz_ff <= nz1;
      end

      if (cmd.div_load) begin
         dvd_ff <= mag_num + {{(64-CNT_W-14){1'b0}}, cnt_ff, 14'b0};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? (rs - den) : rs;
         dvd_ff <= {dvd_ff[62:0], ge};
      end

      if (cmd.out_load) begin
         rsp_fit_valid   <= cmd.out_fit;
         rsp_normal_s    <= cmd.out_fit ? ns_ff : 16'sd0;
         rsp_normal_z    <= cmd.out_fit ? nz_ff : 16'sd0;
         rsp_line_offset <= cmd.out_fit ? off : 24'sd0;
      end
   end

endmodule

[rtl/total_least_squares_line_fit.sv]
// Top level of the total least squares (s, z) line fit.
`timescale 1ns / 1ps
// Streams (s, z) points, one transfer per cycle while req_stall is low, into
// running sums of the count, s, z, s*s, z*z and s*z; points past MAX_POINTS
// are dropped but a last marker still ends the run. The three point products
// come from a two-stage input pipeline, so points accumulate at full rate.
// After the transfer that carries last, the input stalls until the result is
// loaded: that pipeline drains, then one shift-add multiplier forms the
// n-scaled scatter terms (six products), a normalizer shifts them into range,
// a shared CORDIC unit runs CORDIC_STEPS (capped at ATAN_ENTRIES) vectoring
// and as many rotation iterations, two more products give the offset
// numerator and a restoring divider forms the offset. The end of a run also
// waits while an earlier result still sits in the output register; a fit with
// fewer than two points or isotropic spread skips the normalizer, CORDIC and
// divide and reports fit_valid low with zero fields. The result sits in an
// output register until its transfer; the sums clear when it is loaded.
module total_least_squares_line_fit #(
   parameter int MAX_POINTS   = 1024,
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [19:0] req_s_pos,
   input  logic signed [19:0] req_z_pos,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normal_s,
   output logic signed [15:0] rsp_normal_z,
   output logic signed [23:0] rsp_line_offset,
   output logic               rsp_fit_valid
);

   tlslf_pkg::cmd_type    cmd;
   tlslf_pkg::status_type status;

   // sequencer: owns the state, iteration counts and the fit flag
   tlslf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic: sums, multiplier, CORDIC, divider and the output register
   tlslf_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_s_pos       (req_s_pos),
      .req_z_pos       (req_z_pos),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_normal_s    (rsp_normal_s),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_line_offset (rsp_line_offset),
      .rsp_fit_valid   (rsp_fit_valid)
   );

endmodule

[rtl/tlslf_checker.sv]
// Port-level checks of the line fit, bound to the top level.
`timescale 1ns / 1ps
`include "total_least_squares_line_fit_defines.svh"
module tlslf_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_normal_s,
   input logic signed [15:0] rsp_normal_z,
   input logic signed [23:0] rsp_line_offset,
   input logic               rsp_fit_valid
);

   `TLSLF_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `TLSLF_ASSERT_IMP(a_bad_fit_zero, rsp_valid && !rsp_fit_valid, (rsp_normal_s == 16'sd0) && (rsp_normal_z == 16'sd0) && (rsp_line_offset == 24'sd0))
   `TLSLF_ASSERT_IMP(a_nz_nonneg, rsp_valid && rsp_fit_valid, !rsp_normal_z[15])
   `TLSLF_ASSERT_IMP(a_idle_after_reset, $past(reset), !rsp_valid)

endmodule

bind total_least_squares_line_fit tlslf_checker u_tlslf_checker (.*);
